// File: src/round_robin_lock_handoff_top_assert.svh
// Assertion macros used by the checker of the lock handoff block.
`ifndef ROUND_ROBIN_LOCK_HANDOFF_TOP_ASSERT_SVH
`define ROUND_ROBIN_LOCK_HANDOFF_TOP_ASSERT_SVH

// Check cons in the same cycle as ante.
`define RRLH_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rrlh same-cycle check failed");

// Check cons in the cycle after ante.
`define RRLH_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rrlh next-cycle check failed");

`endif

// File: src/rrlh_pkg.sv
package rrlh_pkg;

  localparam int OP_W     = 1;
  localparam int TID_W    = 6;
  localparam int ACT_W    = 7;
  localparam int TID_SPAN = 64;
  localparam int PADDR_W  = 2;
  localparam int PDATA_W  = 32;

  localparam logic [OP_W-1:0] OP_LOCK    = 1'b0;
  localparam logic [OP_W-1:0] OP_RELEASE = 1'b1;

  localparam logic [PADDR_W-1:0] ADDR_ACTIVE_THREADS = 2'd0;
  localparam logic [ACT_W-1:0]   ACTIVE_RESET        = 7'd64;

  // Per-cell control from the sequencer.
  typedef struct packed {
    logic shift;
    logic wrap;
    logic set;
    logic clr;
  } cell_ctl_t;

endpackage

// File: src/rrlh_if.sv
interface rrlh_req_if;
  logic                         valid;
  logic                         ready;
  logic [rrlh_pkg::OP_W-1:0]    op;
  logic [rrlh_pkg::TID_W-1:0]   thread_sel;

  modport source (output valid, op, thread_sel, input ready);
  modport sink (input valid, op, thread_sel, output ready);
endinterface

interface rrlh_rsp_if;
  logic                         valid;
  logic                         ready;
  logic                         grant_valid;
  logic [rrlh_pkg::TID_W-1:0]   grant_thread;
  logic                         lock_free;
  logic                         bad_thread;

  modport source (output valid, grant_valid, grant_thread, lock_free, bad_thread,
                  input ready);
  modport sink (input valid, grant_valid, grant_thread, lock_free, bad_thread,
                output ready);
endinterface

// File: src/round_robin_lock_handoff_top.sv
// Channel   Dir  Payload                                          Transfer
// req       in   op, thread_sel                                   valid & ready
// rsp       out  grant_valid, grant_thread, lock_free, bad_thread valid & ready
// apb cfg   in   active_threads at byte 0                         psel&penable&pwrite
//
// Lock requests and out-of-range items are registered as a pending result, which
// moves to the output register once that is free; the next transfer is taken after
// the move. A release first runs the scan over L = min(effective count, 64) cells
// and a finish step, then delivers the same way: the waiting marks rotate through
// the row one cell per cycle and the head cell is examined each cycle; the rotation
// length bounds the scan. One item is in flight at a time; req.ready is high only
// while idle. A finished result moves to the output register and waits there for
// rsp.ready while the next item is taken; a second result stalls until it drains.
// Reset clears the marks at once (no clearing pass) and frees the lock.
module round_robin_lock_handoff_top #(
  parameter int MAX_THREADS = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  rrlh_req_if.sink                      req,
  rrlh_rsp_if.source                    rsp,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rrlh_pkg::PADDR_W-1:0]  paddr,
  input  logic [rrlh_pkg::PDATA_W-1:0]  pwdata,
  output logic [rrlh_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  // Only ids below 64 can ever hold a mark, so the row stops there.
  localparam int NCELL = (MAX_THREADS < rrlh_pkg::TID_SPAN) ? MAX_THREADS
                                                             : rrlh_pkg::TID_SPAN;
  localparam int IDX_W = $clog2(NCELL);
  localparam int LW    = $clog2(NCELL + 1);
  localparam int CNT_W = $clog2(MAX_THREADS + 1);
  localparam int NW    = (CNT_W > rrlh_pkg::ACT_W) ? CNT_W : rrlh_pkg::ACT_W;
  localparam int TW    = rrlh_pkg::TID_W;

  localparam logic [1:0] ST_IDLE    = 2'd0;
  localparam logic [1:0] ST_SCAN    = 2'd1;
  localparam logic [1:0] ST_FINISH  = 2'd2;
  localparam logic [1:0] ST_DELIVER = 2'd3;

  logic [1:0]                  state;
  logic [rrlh_pkg::ACT_W-1:0]  active_threads;
  logic                        free_flag;

  // Release scan context
  logic [IDX_W-1:0]            tid_r;
  logic [IDX_W-1:0]            step;
  logic                        hi_found;
  logic                        lo_found;
  logic [IDX_W-1:0]            hi_idx;
  logic [IDX_W-1:0]            lo_idx;

  // Finished result, waiting for the output register
  logic                        res_grant_valid;
  logic [TW-1:0]               res_grant_thread;
  logic                        res_lock_free;
  logic                        res_bad;

  // Output register
  logic                        out_valid;
  logic                        out_grant_valid;
  logic [TW-1:0]               out_grant_thread;
  logic                        out_lock_free;
  logic                        out_bad;

  logic [NW-1:0]               act_ext;
  logic [NW-1:0]               n_floor;
  logic [NW-1:0]               eff_n;
  logic [LW-1:0]               scan_len;
  logic                        in_bad;
  logic                        in_fire;
  logic                        cfg_write;
  logic                        last_step;
  logic                        found;
  logic [IDX_W-1:0]            win;
  logic                        out_load;
  logic                        set_en;
  logic [NCELL-1:0]            marks;
  rrlh_pkg::cell_ctl_t         cell_ctl [NCELL];

  // Effective count: zero acts as one, saturate at MAX_THREADS.
  assign act_ext  = NW'(active_threads);
  assign n_floor  = (act_ext == '0) ? NW'(1) : act_ext;
  assign eff_n    = (n_floor > NW'(MAX_THREADS)) ? NW'(MAX_THREADS) : n_floor;
  assign scan_len = (eff_n > NW'(NCELL)) ? LW'(NCELL) : LW'(eff_n);

  assign in_bad    = NW'(req.thread_sel) >= eff_n;
  assign req.ready = (state == ST_IDLE);
  assign in_fire   = req.valid && req.ready;
  assign set_en    = in_fire && (req.op == rrlh_pkg::OP_LOCK) && !in_bad && !free_flag;

  assign last_step = (LW'(step) == (scan_len - LW'(1)));
  // Prefer the first waiter above the releaser, then wrap to the first one below.
  assign found     = hi_found || lo_found;
  assign win       = hi_found ? hi_idx : lo_idx;
  assign out_load  = (state == ST_DELIVER) && (!out_valid || rsp.ready);

  assign cfg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;
  assign prdata    = {{(rrlh_pkg::PDATA_W - rrlh_pkg::ACT_W){1'b0}}, active_threads};

  assign rsp.valid        = out_valid;
  assign rsp.grant_valid  = out_grant_valid;
  assign rsp.grant_thread = out_grant_thread;
  assign rsp.lock_free    = out_lock_free;
  assign rsp.bad_thread   = out_bad;

  // Row of mark cells. Cells inside the scan length rotate toward cell 0, and the
  // last active cell takes cell 0's mark, so one full rotation restores the row.
  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    always_comb begin
      cell_ctl[i].shift = (state == ST_SCAN) && (LW'(i) < scan_len);
      cell_ctl[i].wrap  = (LW'(i) == (scan_len - LW'(1)));
      cell_ctl[i].set   = set_en && (req.thread_sel == TW'(i));
      cell_ctl[i].clr   = (state == ST_FINISH) && found && (win == IDX_W'(i));
    end

    rrlh_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (cell_ctl[i]),
      .from_next (marks[(i + 1) % NCELL]),
      .from_head (marks[0]),
      .mark      (marks[i])
    );
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      active_threads <= rrlh_pkg::ACTIVE_RESET;
      free_flag      <= 1'b1;
      out_valid      <= 1'b0;
      hi_found       <= 1'b0;
      lo_found       <= 1'b0;
    end else begin
      if (cfg_write && (paddr == rrlh_pkg::ADDR_ACTIVE_THREADS)) begin
        active_threads <= pwdata[rrlh_pkg::ACT_W-1:0];
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            if (in_bad) begin
              state <= ST_DELIVER;
            end else if (req.op == rrlh_pkg::OP_LOCK) begin
              free_flag <= 1'b0;
              state     <= ST_DELIVER;
            end else begin
              hi_found <= 1'b0;
              lo_found <= 1'b0;
              state    <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          // Head cell holds thread 'step'; skip the releaser's own mark.
          if (marks[0] && (step != tid_r)) begin
            if ((step > tid_r) && !hi_found) begin
              hi_found <= 1'b1;
            end
            if ((step < tid_r) && !lo_found) begin
              lo_found <= 1'b1;
            end
          end
          if (last_step) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          free_flag <= !found;
          state     <= ST_DELIVER;
        end
        ST_DELIVER: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Payload: scan context, pending result and output fields
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        tid_r            <= req.thread_sel[IDX_W-1:0];
        step             <= '0;
        res_grant_valid  <= 1'b0;
        res_grant_thread <= '0;
        res_lock_free    <= free_flag;
        res_bad          <= in_bad;
        if (!in_bad && (req.op == rrlh_pkg::OP_LOCK)) begin
          res_lock_free <= 1'b0;
          if (free_flag) begin
            res_grant_valid  <= 1'b1;
            res_grant_thread <= req.thread_sel;
          end
        end
      end
      ST_SCAN: begin
        step <= step + IDX_W'(1);
        if (marks[0] && (step > tid_r) && !hi_found) begin
          hi_idx <= step;
        end
        if (marks[0] && (step < tid_r) && !lo_found) begin
          lo_idx <= step;
        end
      end
      ST_FINISH: begin
        res_grant_valid  <= found;
        res_grant_thread <= found ? TW'(win) : '0;
        res_lock_free    <= !found;
        res_bad          <= 1'b0;
      end
      default: begin
        res_bad <= res_bad;
      end
    endcase

    if (out_load) begin
      out_grant_valid  <= res_grant_valid;
      out_grant_thread <= res_grant_thread;
      out_lock_free    <= res_lock_free;
      out_bad          <= res_bad;
    end
  end

endmodule

// File: src/rrlh_cell.sv
module rrlh_cell (
  input  logic                clk,
  input  logic                rst,
  input  rrlh_pkg::cell_ctl_t ctl,
  input  logic                from_next,
  input  logic                from_head,
  output logic                mark
);

  // Rotate during a scan, otherwise take set or clear.
  always_ff @(posedge clk) begin
    if (rst) begin
      mark <= 1'b0;
    end else if (ctl.shift) begin
      mark <= ctl.wrap ? from_head : from_next;
    end else if (ctl.set) begin
      mark <= 1'b1;
    end else if (ctl.clr) begin
      mark <= 1'b0;
    end
  end

endmodule

// File: src/rrlh_checker.sv
`include "round_robin_lock_handoff_top_assert.svh"

module rrlh_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        grant_valid,
  input logic [rrlh_pkg::TID_W-1:0]  grant_thread,
  input logic                        lock_free,
  input logic                        bad_thread
);

  // A stalled result stays offered.
  `RRLH_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)
  // One item at a time: after a transfer in, the input closes.
  `RRLH_ASSERT_NEXT(a_one_item, clk, rst, in_valid && in_ready, !in_ready)
  // A grant always leaves the lock owned.
  `RRLH_ASSERT_SAME(a_grant_busy, clk, rst, out_valid && grant_valid, !lock_free)
  // An ignored item never grants.
  `RRLH_ASSERT_SAME(a_bad_quiet, clk, rst, out_valid && bad_thread, !grant_valid)
  // A result without a grant shows thread zero.
  `RRLH_ASSERT_SAME(a_idle_id, clk, rst, out_valid && !grant_valid, grant_thread == '0)

endmodule

bind round_robin_lock_handoff_top rrlh_checker u_rrlh_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (req.valid),
  .in_ready     (req.ready),
  .out_valid    (rsp.valid),
  .out_ready    (rsp.ready),
  .grant_valid  (rsp.grant_valid),
  .grant_thread (rsp.grant_thread),
  .lock_free    (rsp.lock_free),
  .bad_thread   (rsp.bad_thread)
);

// File: sim/round_robin_lock_handoff_top_test.sv
module round_robin_lock_handoff_top_test;

  localparam int MAX_THREADS    = 64;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int PHASE_OPS      = 78;
  localparam int NUM_PHASES     = 11;
  localparam int SETTLE_CYCLES  = 70;
  localparam int OP_BITS        = rrlh_pkg::OP_W;
  localparam int TID_BITS       = rrlh_pkg::TID_W;
  localparam int ACT_BITS       = rrlh_pkg::ACT_W;
  localparam int DATA_BITS      = rrlh_pkg::PDATA_W;

  // One lock command as it goes into the request channel.
  typedef struct packed {
    logic [OP_BITS-1:0]  op;
    logic [TID_BITS-1:0] thread_sel;
  } lock_cmd_t;

  // One handoff outcome as it comes out of the response channel.
  typedef struct packed {
    logic                grant_valid;
    logic [TID_BITS-1:0] grant_thread;
    logic                lock_free;
    logic                bad_thread;
  } handoff_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                         psel    = 1'b0;
  logic                         penable = 1'b0;
  logic                         pwrite  = 1'b0;
  logic [rrlh_pkg::PADDR_W-1:0] paddr   = '0;
  logic [DATA_BITS-1:0]         pwdata  = '0;
  logic [DATA_BITS-1:0]         prdata;
  logic                         pready;

  rrlh_req_if req ();
  rrlh_rsp_if rsp ();

  round_robin_lock_handoff_top #(
    .MAX_THREADS(MAX_THREADS)
  ) u_dut (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .rsp    (rsp),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow of the lock state: one waiting mark per thread, the free flag and the
  // thread count register as last written.
  logic [MAX_THREADS-1:0] waiting_mask;
  logic                   lock_is_free;
  logic [ACT_BITS-1:0]    thread_count_reg;

  lock_cmd_t pending_cmds[$];
  handoff_t  expected_handoffs[$];

  int send_gap_max = 0;
  int recv_gap_max = 0;
  int send_wait;
  int recv_wait;
  int error_count  = 0;
  int idle_cycles  = 0;

  // Zero acts as one thread, anything above the array size saturates.
  function automatic int effective_count(logic [ACT_BITS-1:0] setting);
    if (setting == '0) return 1;
    if (setting > MAX_THREADS) return MAX_THREADS;
    return int'(setting);
  endfunction

  // Apply one command to the shadow state and return the handoff it causes.
  function automatic handoff_t predict_handoff(logic [OP_BITS-1:0] op,
                                               logic [TID_BITS-1:0] tid);
    handoff_t res;
    int       n;
    int       idx;
    bit       found;
    res   = '0;
    n     = effective_count(thread_count_reg);
    found = 1'b0;
    if (int'(tid) >= n) begin
      // Out-of-range thread: state untouched, flag it.
      res.bad_thread = 1'b1;
    end else if (op == rrlh_pkg::OP_LOCK) begin
      if (lock_is_free) begin
        lock_is_free     = 1'b0;
        res.grant_valid  = 1'b1;
        res.grant_thread = tid;
      end else begin
        waiting_mask[tid] = 1'b1;
      end
    end else begin
      // Scan round-robin from the thread after the releaser, never the releaser.
      for (int k = 1; k < n && !found; k++) begin
        idx = (int'(tid) + k) % n;
        if (waiting_mask[idx[TID_BITS-1:0]]) begin
          waiting_mask[idx[TID_BITS-1:0]] = 1'b0;
          lock_is_free      = 1'b0;
          res.grant_valid   = 1'b1;
          res.grant_thread  = idx[TID_BITS-1:0];
          found             = 1'b1;
        end
      end
      if (!found) lock_is_free = 1'b1;
    end
    res.lock_free = lock_is_free;
    return res;
  endfunction

  task automatic queue_op(logic [OP_BITS-1:0] op, logic [TID_BITS-1:0] tid);
    lock_cmd_t cmd;
    cmd.op         = op;
    cmd.thread_sel = tid;
    pending_cmds.push_back(cmd);
  endtask

  // Mostly in-range threads, with a hot set of low ids so that the same threads
  // collide, queue up and get handed the lock; a few ids anywhere in the field.
  task automatic queue_random_ops(int count);
    int                  n;
    int                  pick;
    logic [TID_BITS-1:0] tid;
    n = effective_count(thread_count_reg);
    repeat (count) begin
      pick = $urandom_range(0, 9);
      if (pick == 0)
        tid = TID_BITS'($urandom_range(0, MAX_THREADS - 1));
      else if (pick <= 3)
        tid = TID_BITS'($urandom_range(0, ((n < 4) ? n : 4) - 1));
      else
        tid = TID_BITS'($urandom_range(0, n - 1));
      queue_op(OP_BITS'($urandom_range(0, 1)), tid);
    end
  endtask

  // Hold until the sender has nothing left and every expected handoff is back.
  task automatic wait_until_idle();
    while (pending_cmds.size() != 0 || req.valid || expected_handoffs.size() != 0)
      @(posedge clk);
  endtask

  // Write the thread count register: setup cycle, then access cycle.
  task automatic set_thread_count(logic [ACT_BITS-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= rrlh_pkg::ADDR_ACTIVE_THREADS;
    pwdata  <= DATA_BITS'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    // The register takes the value at this edge; the lock state is untouched.
    thread_count_reg = value;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Request driver: draw a gap per command, hold valid until the transfer.
  always @(posedge clk) begin
    if (rst) begin
      req.valid      <= 1'b0;
      req.op         <= rrlh_pkg::OP_LOCK;
      req.thread_sel <= '0;
      send_wait = 0;
    end else if (!req.valid || req.ready) begin
      if (req.valid) begin
        // Transfer at this edge: predict now, while the shadow matches the block.
        expected_handoffs.push_back(predict_handoff(req.op, req.thread_sel));
        send_wait = $urandom_range(0, send_gap_max);
      end
      if (send_wait == 0 && pending_cmds.size() != 0) begin
        req.valid      <= 1'b1;
        req.op         <= pending_cmds[0].op;
        req.thread_sel <= pending_cmds[0].thread_sel;
        void'(pending_cmds.pop_front());
      end else begin
        if (send_wait != 0) send_wait--;
        req.valid <= 1'b0;
      end
    end
  end

  // Response monitor: compare each transfer with the oldest expectation, then
  // stall for a freshly drawn number of cycles.
  always @(posedge clk) begin
    handoff_t got;
    handoff_t want;
    if (rst) begin
      rsp.ready <= 1'b0;
      recv_wait = 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        got.grant_valid  = rsp.grant_valid;
        got.grant_thread = rsp.grant_thread;
        got.lock_free    = rsp.lock_free;
        got.bad_thread   = rsp.bad_thread;
        if (expected_handoffs.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result gv=%0d gt=%0d free=%0d bad=%0d", $time,
                   got.grant_valid, got.grant_thread, got.lock_free, got.bad_thread);
        end else begin
          want = expected_handoffs.pop_front();
          if (got !== want) begin
            error_count++;
            $display("%0t: expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                     $time, want.grant_valid, want.grant_thread, want.lock_free,
                     want.bad_thread, got.grant_valid, got.grant_thread, got.lock_free,
                     got.bad_thread);
          end
        end
        recv_wait = $urandom_range(0, recv_gap_max);
      end
      if (recv_wait != 0) begin
        recv_wait--;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  // Watchdog: any transfer or register access resets the count.
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready) || psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [ACT_BITS-1:0] phase_count;
    waiting_mask     = '0;
    lock_is_free     = 1'b1;
    thread_count_reg = rrlh_pkg::ACTIVE_RESET;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed, full thread count: grant while free, queue waiters, hand off in
    // round-robin order with a wrap, release while free, owner re-requesting and
    // then releasing (its own mark stays set).
    send_gap_max = 0;
    recv_gap_max = 0;
    queue_op(rrlh_pkg::OP_LOCK,    6'd0);
    queue_op(rrlh_pkg::OP_LOCK,    6'd63);
    queue_op(rrlh_pkg::OP_LOCK,    6'd5);
    queue_op(rrlh_pkg::OP_LOCK,    6'd5);
    queue_op(rrlh_pkg::OP_LOCK,    6'd0);
    queue_op(rrlh_pkg::OP_RELEASE, 6'd0);
    queue_op(rrlh_pkg::OP_RELEASE, 6'd5);
    queue_op(rrlh_pkg::OP_RELEASE, 6'd63);
    queue_op(rrlh_pkg::OP_RELEASE, 6'd0);
    queue_op(rrlh_pkg::OP_RELEASE, 6'd10);
    queue_op(rrlh_pkg::OP_LOCK,    6'd42);
    queue_op(rrlh_pkg::OP_LOCK,    6'd42);
    queue_op(rrlh_pkg::OP_RELEASE, 6'd42);
    queue_op(rrlh_pkg::OP_LOCK,    6'd1);
    queue_op(rrlh_pkg::OP_RELEASE, 6'd1);
    queue_op(rrlh_pkg::OP_LOCK,    6'd42);
    queue_op(rrlh_pkg::OP_LOCK,    6'd42);
    queue_op(rrlh_pkg::OP_RELEASE, 6'd42);

    // Reduced count: the leftover mark on thread 42 must not be scanned, and ids
    // at or above the count are flagged without touching the lock.
    wait_until_idle();
    set_thread_count(7'd10);
    send_gap_max = 8;
    recv_gap_max = 8;
    queue_op(rrlh_pkg::OP_LOCK,    6'd10);
    queue_op(rrlh_pkg::OP_LOCK,    6'd63);
    queue_op(rrlh_pkg::OP_LOCK,    6'd9);
    queue_op(rrlh_pkg::OP_RELEASE, 6'd63);
    queue_op(rrlh_pkg::OP_RELEASE, 6'd9);

    // Zero count acts as a single thread: a release has nothing to scan.
    wait_until_idle();
    set_thread_count(7'd0);
    queue_op(rrlh_pkg::OP_LOCK,    6'd1);
    queue_op(rrlh_pkg::OP_LOCK,    6'd0);
    queue_op(rrlh_pkg::OP_LOCK,    6'd0);
    queue_op(rrlh_pkg::OP_RELEASE, 6'd0);

    // Random phases, each at a new thread count and a new mix of sender gaps
    // and receiver stalls; each boundary drains the block before the write.
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0:       phase_count = 7'd64;
        1:       phase_count = 7'd1;
        2:       phase_count = 7'd2;
        3:       phase_count = 7'd3;
        4:       phase_count = 7'd127;
        5:       phase_count = 7'd17;
        6:       phase_count = 7'd0;
        7:       phase_count = 7'd65;
        8:       phase_count = 7'd5;
        9:       phase_count = 7'd64;
        default: phase_count = ACT_BITS'($urandom_range(1, MAX_THREADS));
      endcase
      wait_until_idle();
      set_thread_count(phase_count);
      case (p % 4)
        0: begin
          send_gap_max = 0;
          recv_gap_max = 0;
        end
        1: begin
          send_gap_max = 8;
          recv_gap_max = 8;
        end
        2: begin
          send_gap_max = 8;
          recv_gap_max = 0;
        end
        default: begin
          send_gap_max = 0;
          recv_gap_max = 8;
        end
      endcase
      queue_random_ops(PHASE_OPS);
    end

    // Drain, then give a late stray result time to show up.
    wait_until_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
